>>> src/gdkd_pkg.sv
// shared constants and helpers for the grouped duplicate key detector
// no dependencies; used by the top level, its checker and the testbench

package gdkd_pkg;

    // value and key widths
    localparam int VALUE_W = 64;
    localparam int KEY_W   = 32;

    // key table geometry
    localparam int TABLE_BITS   = 12;
    localparam int BUCKET_SHIFT = 8;
    localparam int SLOT_COUNT   = 1 << TABLE_BITS;

    // group epoch tag stored next to each key
    localparam int EPOCH_W = 8;
    localparam int MEM_W   = EPOCH_W + KEY_W;

    // active size register
    localparam int CFG_W = 4;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(12);

    typedef logic [TABLE_BITS-1:0] t_slot;
    typedef logic [EPOCH_W-1:0]    t_epoch;
    typedef logic [KEY_W-1:0]      t_key;

    // slot mask for a given size, clamped to the full table
    function automatic t_slot slot_mask(input logic [CFG_W-1:0] bits);
        logic [TABLE_BITS:0] one_hot;
        t_slot               mask;
        one_hot = (TABLE_BITS+1)'(1) << bits;
        if (int'(bits) >= TABLE_BITS) begin
            mask = '1;
        end else begin
            mask = one_hot[TABLE_BITS-1:0] - t_slot'(1);
        end
        return mask;
    endfunction

endpackage

>>> src/grouped_duplicate_key_detector.sv
// grouped duplicate key detector: linear probing hash set in one synchronous memory
// depends on gdkd_pkg
//
// one item at a time: input ready is high only when idle, after the last item's result
// beat has been registered; a stalled result beat holds back the settling search
// a new group bumps an epoch tag instead of clearing; every 255 groups the epoch
// wraps and a clearing pass over all SLOT_COUNT (4096) slots runs before that item
// after reset a clearing pass over all SLOT_COUNT slots runs with input ready low;
// configuration writes are taken at all times

module grouped_duplicate_key_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input beats
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [gdkd_pkg::VALUE_W-1:0]  i_value,
    input  logic                          i_first_of_group,
    // result beats
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_duplicate,
    output logic                          o_group_has_duplicate,
    // size register writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gdkd_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_CHECK = 2'd3;

    // key table: {epoch, key} per slot
    logic [gdkd_pkg::MEM_W-1:0] r_mem [gdkd_pkg::SLOT_COUNT];
    logic [gdkd_pkg::MEM_W-1:0] r_rd_data;

    logic [1:0]                 r_state, n_state;
    logic [gdkd_pkg::CFG_W-1:0] r_cfg;
    gdkd_pkg::t_epoch           r_epoch, n_epoch;
    gdkd_pkg::t_slot            r_clr, n_clr;
    logic                       r_pend, n_pend;
    gdkd_pkg::t_key             r_key, n_key;
    gdkd_pkg::t_slot            r_slot, n_slot;
    gdkd_pkg::t_slot            r_cnt, n_cnt;
    gdkd_pkg::t_slot            r_mask, n_mask;
    logic                       r_grp, n_grp;
    logic                       r_out_valid, n_out_valid;
    logic                       r_dup, n_dup;
    logic                       r_gdup, n_gdup;

    logic                       mem_we, mem_re;
    gdkd_pkg::t_slot            mem_waddr, mem_raddr;
    logic [gdkd_pkg::MEM_W-1:0] mem_wdata;

    logic                       in_acc;
    logic                       out_free;
    gdkd_pkg::t_slot            mask_now;
    gdkd_pkg::t_slot            home_in;
    gdkd_pkg::t_key             key_in;
    gdkd_pkg::t_epoch           held_tag;
    gdkd_pkg::t_key             held_key;
    logic                       held_live;

    assign o_in_ready            = (r_state == ST_IDLE);
    assign o_cfg_ready           = 1'b1;
    assign o_out_valid           = r_out_valid;
    assign o_duplicate           = r_dup;
    assign o_group_has_duplicate = r_gdup;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // key and home slot of the incoming value
    assign mask_now = gdkd_pkg::slot_mask(r_cfg);
    assign home_in  = i_value[gdkd_pkg::BUCKET_SHIFT +: gdkd_pkg::TABLE_BITS] & mask_now;
    assign key_in   = i_value[gdkd_pkg::VALUE_W-1:gdkd_pkg::KEY_W]
                    + i_value[gdkd_pkg::KEY_W-1:0];

    // slot read back from the table
    assign held_tag  = r_rd_data[gdkd_pkg::MEM_W-1:gdkd_pkg::KEY_W];
    assign held_key  = r_rd_data[gdkd_pkg::KEY_W-1:0];
    assign held_live = (held_tag == r_epoch);

    // sequencer: clear, accept, probe
    always_comb begin
        n_state     = r_state;
        n_epoch     = r_epoch;
        n_clr       = r_clr;
        n_pend      = r_pend;
        n_key       = r_key;
        n_slot      = r_slot;
        n_cnt       = r_cnt;
        n_mask      = r_mask;
        n_grp       = r_grp;
        n_out_valid = r_out_valid && !i_out_ready;
        n_dup       = r_dup;
        n_gdup      = r_gdup;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = r_clr;
        mem_raddr   = r_slot;
        mem_wdata   = '0;
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + gdkd_pkg::t_slot'(1);
                if (r_clr == '1) begin
                    n_epoch = gdkd_pkg::t_epoch'(1);
                    n_pend  = 1'b0;
                    n_state = r_pend ? ST_READ : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    mem_re    = 1'b1;
                    mem_raddr = home_in;
                    n_slot    = home_in;
                    n_key     = key_in;
                    n_cnt     = '0;
                    n_mask    = mask_now;
                    n_state   = ST_CHECK;
                    if (i_first_of_group) begin
                        n_grp = 1'b0;
                        if (r_epoch == '1) begin
                            n_pend  = 1'b1;
                            n_state = ST_CLEAR;
                        end else begin
                            n_epoch = r_epoch + gdkd_pkg::t_epoch'(1);
                        end
                    end
                end
            end
            ST_READ: begin
                mem_re    = 1'b1;
                mem_raddr = r_slot;
                n_state   = ST_CHECK;
            end
            ST_CHECK: begin
                if (r_key != '0 && held_live && held_key != r_key && r_cnt != r_mask) begin
                    // occupied by another key: step to the next slot
                    mem_re    = 1'b1;
                    mem_raddr = (r_slot + gdkd_pkg::t_slot'(1)) & r_mask;
                    n_slot    = mem_raddr;
                    n_cnt     = r_cnt + gdkd_pkg::t_slot'(1);
                end else if (out_free) begin
                    // search settled: report and store on an empty slot
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                    n_dup       = (r_key != '0) && held_live && (held_key == r_key);
                    n_grp       = r_grp || n_dup;
                    n_gdup      = n_grp;
                    if (r_key != '0 && !held_live) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_slot;
                        mem_wdata = {r_epoch, r_key};
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_epoch     <= gdkd_pkg::t_epoch'(1);
            r_clr       <= '0;
            r_pend      <= 1'b0;
            r_grp       <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg       <= gdkd_pkg::CFG_RESET;
        end else begin
            r_state     <= n_state;
            r_epoch     <= n_epoch;
            r_clr       <= n_clr;
            r_pend      <= n_pend;
            r_grp       <= n_grp;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_slot <= n_slot;
        r_cnt  <= n_cnt;
        r_mask <= n_mask;
        r_dup  <= n_dup;
        r_gdup <= n_gdup;
    end

    // key table memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

endmodule

>>> src/gdkd_checker.sv
// port-level checks for the grouped duplicate key detector, bound to the top level
// depends on gdkd_pkg and grouped_duplicate_key_detector

module gdkd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic [gdkd_pkg::VALUE_W-1:0]  i_value,
    input logic                          i_first_of_group,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic                          o_duplicate,
    input logic                          o_group_has_duplicate,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready
);

    // a duplicate always shows in the group flag
    a_dup_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_duplicate || o_group_has_duplicate))
        else $error("duplicate reported without group flag");

    // one item at a time: ready drops after an accepted beat
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready held after accept");

    // a waiting input beat holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_ready) |=>
            (i_in_valid && $stable(i_value) && $stable(i_first_of_group)))
        else $error("input beat changed while waiting");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_duplicate) && $stable(o_group_has_duplicate)))
        else $error("result beat changed while stalled");

    // size register writes are never back-pressured
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write stalled");

endmodule

bind grouped_duplicate_key_detector gdkd_checker u_gdkd_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_in_valid            (i_in_valid),
    .o_in_ready            (o_in_ready),
    .i_value               (i_value),
    .i_first_of_group      (i_first_of_group),
    .o_out_valid           (o_out_valid),
    .i_out_ready           (i_out_ready),
    .o_duplicate           (o_duplicate),
    .o_group_has_duplicate (o_group_has_duplicate),
    .i_cfg_valid           (i_cfg_valid),
    .o_cfg_ready           (o_cfg_ready)
);

>>> test/tb_top.sv
`timescale 1ns / 100ps
// testbench for grouped_duplicate_key_detector: directed and random groups of values
// each result beat is checked against a linear probing key table kept in the bench
// depends on gdkd_pkg and the detector top level

module tb_top;

    localparam int CLK_HALF    = 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SHOW_LIMIT  = 10;

    typedef struct packed {
        logic duplicate;
        logic group_dup;
    } t_verdict;

    // dut connections, all inputs known from time zero
    logic                         i_clk            = 1'b0;
    logic                         i_rst_n          = 1'b0;
    logic                         i_in_valid       = 1'b0;
    logic                         o_in_ready;
    logic [gdkd_pkg::VALUE_W-1:0] i_value          = '0;
    logic                         i_first_of_group = 1'b0;
    logic                         o_out_valid;
    logic                         i_out_ready      = 1'b0;
    logic                         o_duplicate;
    logic                         o_group_has_duplicate;
    logic                         i_cfg_valid      = 1'b0;
    logic                         o_cfg_ready;
    logic [gdkd_pkg::CFG_W-1:0]   i_cfg_data       = '0;

    // bench copy of the key table, sticky flag and size register
    gdkd_pkg::t_key             shadow_keys [gdkd_pkg::SLOT_COUNT];
    logic                       shadow_group_dup;
    logic [gdkd_pkg::CFG_W-1:0] shadow_bits;

    // verdicts waiting for their result beats
    t_verdict verdict_q [$];

    int unsigned cycle_cnt    = 0;
    int unsigned items_sent   = 0;
    int unsigned groups_sent  = 0;
    int unsigned results_seen = 0;
    int unsigned dups_seen    = 0;
    int unsigned cfg_writes   = 0;
    int unsigned mismatches   = 0;
    int unsigned burst_left   = 0;
    logic [15:0] stall_bits   = 16'hFFFF;

    grouped_duplicate_key_detector u_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_value               (i_value),
        .i_first_of_group      (i_first_of_group),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_duplicate           (o_duplicate),
        .o_group_has_duplicate (o_group_has_duplicate),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_data            (i_cfg_data)
    );

    // clock
    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // empty the bench table at a group start
    function automatic void clear_shadow();
        for (int s = 0; s < gdkd_pkg::SLOT_COUNT; s++) begin
            shadow_keys[s] = '0;
        end
        shadow_group_dup = 1'b0;
    endfunction

    // linear probe from the home slot, storing the key at the first empty slot
    function automatic logic probe_key_set(input logic [gdkd_pkg::VALUE_W-1:0] v);
        gdkd_pkg::t_key key;
        int unsigned    width;
        int unsigned    span;
        int unsigned    home;
        int unsigned    slot;
        key   = v[63:32] + v[31:0];
        width = (shadow_bits > gdkd_pkg::TABLE_BITS) ? gdkd_pkg::TABLE_BITS : shadow_bits;
        span  = 1 << width;
        home  = int'((v >> gdkd_pkg::BUCKET_SHIFT) & 64'(span - 1));
        // a zero key reads as an empty slot, so it is never stored
        if (key == '0) begin
            return 1'b0;
        end
        for (int n = 0; n < span; n++) begin
            slot = (home + n) % span;
            if (shadow_keys[slot] == '0) begin
                shadow_keys[slot] = key;
                return 1'b0;
            end
            if (shadow_keys[slot] == key) begin
                return 1'b1;
            end
        end
        // every active slot taken by other keys: dropped
        return 1'b0;
    endfunction

    // expected result beat for one accepted value
    function automatic t_verdict judge_value(input logic [gdkd_pkg::VALUE_W-1:0] v,
                                             input logic first);
        t_verdict vd;
        if (first) begin
            clear_shadow();
        end
        vd.duplicate = probe_key_set(v);
        if (vd.duplicate) begin
            shadow_group_dup = 1'b1;
        end
        vd.group_dup = shadow_group_dup;
        return vd;
    endfunction

    // random value, often tied to one already sent in the group
    function automatic logic [gdkd_pkg::VALUE_W-1:0] pick_value(
        input logic [gdkd_pkg::VALUE_W-1:0] earlier [$]);
        logic [gdkd_pkg::VALUE_W-1:0] base;
        logic [31:0]                  hi;
        logic [31:0]                  lo;
        logic [31:0]                  d;
        int unsigned                  roll;
        roll = $urandom_range(0, 99);
        hi   = $urandom;
        lo   = $urandom;
        if (earlier.size() != 0) begin
            base = earlier[$urandom_range(0, earlier.size() - 1)];
        end else begin
            base = {hi, lo};
        end
        // plain repeat
        if (roll < 25 && earlier.size() != 0) begin
            return base;
        end
        // other value with the same key and the same home slot
        if (roll < 35) begin
            d = 32'($urandom_range(1, 4095)) << 20;
            return {base[63:32] + d, base[31:0] - d};
        end
        // halves that sum to a zero key
        if (roll < 42) begin
            return {-lo, lo};
        end
        // same home slot, other key, to grow a probe chain
        if (roll < 55) begin
            return {hi, lo[31:20], base[19:8], lo[7:0]};
        end
        return {hi, lo};
    endfunction

    // log one failed check, details only for the first few
    function automatic void note_mismatch(input string what, input t_verdict want);
        mismatches++;
        if (mismatches <= SHOW_LIMIT) begin
            $display("mismatch at cycle %0d, %s: expected dup=%b grp=%b, got dup=%b grp=%b",
                     cycle_cnt, what, want.duplicate, want.group_dup,
                     o_duplicate, o_group_has_duplicate);
        end
    endfunction

    // send one value beat, with random bursts and gaps around it
    task automatic send_value(input logic [gdkd_pkg::VALUE_W-1:0] v, input logic first);
        int unsigned gap;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge i_clk);
            if ($urandom_range(0, 3) == 0) begin
                burst_left = $urandom_range(20, 60);
            end else begin
                burst_left = $urandom_range(1, 10);
            end
        end
        i_in_valid       <= 1'b1;
        i_value          <= v;
        i_first_of_group <= first;
        do @(posedge i_clk); while (!o_in_ready);
        verdict_q.push_back(judge_value(v, first));
        items_sent++;
        if (first) begin
            groups_sent++;
        end
        burst_left--;
    endtask

    // hold the sender until every result beat is back
    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // size register write, only with the block idle
    task automatic write_table_bits(input logic [gdkd_pkg::CFG_W-1:0] bits);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= bits;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        shadow_bits = bits;
        cfg_writes++;
    endtask

    // zero keys, wrapped keys, repeats, aliases and a group restart
    task automatic test_zero_and_dup_keys();
        wait_results_done();
        write_table_bits(4'd12);
        send_value(64'h0000_0000_0000_0000, 1'b1);
        send_value(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_value(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        // halves sum to zero after the wrap
        send_value(64'hFFFF_FFFF_0000_0001, 1'b0);
        send_value(64'hFFFF_FFFF_0000_0001, 1'b0);
        // two values with one key and one home slot
        send_value(64'h0000_0001_1234_5600, 1'b0);
        send_value(64'h0000_0000_1234_5601, 1'b0);
        // new group forgets the old keys and the sticky flag
        send_value(64'h8000_0000_0000_0000, 1'b1);
        send_value(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    endtask

    // probe chain running off the last slot back to slot zero
    task automatic test_probe_wrap();
        wait_results_done();
        write_table_bits(4'd4);
        send_value(64'h0000_0000_0000_0F00, 1'b1);
        send_value(64'h0000_0000_0000_1F00, 1'b0);
        send_value(64'h0000_0000_0000_2000, 1'b0);
        send_value(64'h0000_0000_0000_1F00, 1'b0);
        send_value(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    endtask

    // single slot table: second key finds no room and is dropped
    task automatic test_table_full();
        wait_results_done();
        write_table_bits(4'd0);
        send_value(64'h0000_0000_0000_0001, 1'b1);
        send_value(64'h0000_0000_0000_0002, 1'b0);
        send_value(64'h0000_0000_0000_0002, 1'b0);
        send_value(64'h0000_0000_0000_0001, 1'b0);
    endtask

    // size change inside a group keeps the stored keys
    task automatic test_resize_mid_group();
        wait_results_done();
        write_table_bits(4'd12);
        send_value(64'h0000_0000_0005_A300, 1'b1);
        wait_results_done();
        write_table_bits(4'd4);
        send_value(64'h0000_0000_0005_A300, 1'b0);
        send_value(64'h0000_0000_0005_A300, 1'b0);
        wait_results_done();
        write_table_bits(4'd12);
        send_value(64'h0000_0000_0005_A300, 1'b0);
    endtask

    // random groups over a range of table sizes, oversized settings too
    task automatic test_random_groups();
        logic [gdkd_pkg::CFG_W-1:0]   bits_list [8] = '{4'd12, 4'd4, 4'd15, 4'd6,
                                                        4'd1, 4'd9, 4'd13, 4'd5};
        logic [gdkd_pkg::VALUE_W-1:0] grp_vals [$];
        logic [gdkd_pkg::VALUE_W-1:0] v;
        int unsigned                  sent;
        int unsigned                  grp_len;
        for (int p = 0; p < 8; p++) begin
            wait_results_done();
            write_table_bits(bits_list[p]);
            sent = 0;
            while (sent < 15) begin
                if ($urandom_range(0, 4) == 0) begin
                    grp_len = $urandom_range(13, 24);
                end else begin
                    grp_len = $urandom_range(1, 8);
                end
                grp_vals.delete();
                for (int i = 0; i < grp_len; i++) begin
                    v = pick_value(grp_vals);
                    grp_vals.push_back(v);
                    send_value(v, i == 0);
                    sent++;
                    // now and then let the pipe run dry mid group
                    if ($urandom_range(0, 39) == 0) begin
                        wait_results_done();
                    end
                end
            end
        end
    endtask

    // many short groups reusing a few values: old groups must stay forgotten
    task automatic test_epoch_wrap();
        logic [gdkd_pkg::VALUE_W-1:0] pool [4];
        logic [gdkd_pkg::VALUE_W-1:0] v;
        wait_results_done();
        write_table_bits(4'd10);
        for (int k = 0; k < 4; k++) begin
            pool[k] = {$urandom, $urandom};
        end
        for (int g = 0; g < 260; g++) begin
            v = pool[$urandom_range(0, 3)];
            send_value(v, 1'b1);
            if ($urandom_range(0, 4) == 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    send_value(v, 1'b0);
                end else begin
                    send_value(pool[$urandom_range(0, 3)], 1'b0);
                end
            end
        end
    endtask

    // result beat checker
    always @(posedge i_clk) begin : check_results
        t_verdict want;
        if (i_rst_n && i_out_ready && o_out_valid) begin
            results_seen++;
            if (o_duplicate === 1'b1) begin
                dups_seen++;
            end
            if (verdict_q.size() == 0) begin
                note_mismatch("result beat with nothing expected", '0);
            end else begin
                want = verdict_q.pop_front();
                if (o_duplicate !== want.duplicate) begin
                    note_mismatch("duplicate", want);
                end else if (o_group_has_duplicate !== want.group_dup) begin
                    note_mismatch("group_has_duplicate", want);
                end
            end
        end
    end

    // receiver stall pattern, redrawn whenever the low byte of the cycle count is zero
    always @(posedge i_clk) begin
        if (cycle_cnt[7:0] == 8'd0) begin
            if ($urandom_range(0, 3) == 0) begin
                stall_bits = 16'hFFFF;
            end else begin
                stall_bits = 16'($urandom) | 16'h0001;
            end
        end
        i_out_ready <= stall_bits[cycle_cnt[3:0]];
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_cnt, verdict_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    // test sequence
    initial begin
        clear_shadow();
        shadow_bits = gdkd_pkg::CFG_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_and_dup_keys();
        test_probe_wrap();
        test_table_full();
        test_resize_mid_group();
        test_random_groups();
        test_epoch_wrap();

        wait_results_done();
        repeat (20) @(posedge i_clk);

        $display("sent %0d values in %0d groups over %0d size settings, %0d flagged duplicate",
                 items_sent, groups_sent, cfg_writes, dups_seen);
        $display("checked %0d result beats, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
